@@ hw/rtl/mrrc_pkg.sv @@
// Shared constants, types and the CRC-16 byte fold for the read response checker.
`timescale 1ns / 1ps
`default_nettype none
package mrrc_pkg;

  localparam int unsigned NUM_WORDS_DEF = 21;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  FUNC_READ   = 8'h03;
  localparam logic [7:0]  SLAVE_RESET = 8'h05;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_HDR = 2'd2,
    ST_CRC = 2'd3
  } status_t;

  typedef struct packed {
    logic frame_end;
    logic frame_ok;
  } mrrc_stat_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/modbus_read_response_checker.sv @@
// Top level of the Modbus read holding registers response checker.
`timescale 1ns / 1ps
`default_nettype none
// Takes a response frame one byte per transaction, one byte per cycle, with
// in_end_of_frame on the final byte. A frame must be 2*NUM_WORDS+5 bytes,
// start with the configured slave address, function code 3 and byte count
// 2*NUM_WORDS, and end in a matching CRC-16 (reflected 0xA001, init 0xFFFF),
// low byte first. After the final byte a good frame yields NUM_WORDS word
// results, one per cycle while out_ready is high, from the registered read
// port of the word store, the first in the cycle after the final byte; a bad
// frame yields one result with status 1 (length), 2 (header) or 3 (CRC).
// No bytes are taken while results are pending, except that the next
// frame's first byte may be taken in the cycle the final result goes out.
// Length is checked before header, header before CRC.
module modbus_read_response_checker #(
  parameter int unsigned NUM_WORDS = mrrc_pkg::NUM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [4:0]       out_word_index,
  output logic [15:0]      out_word_value,
  output logic             out_last_word
);
  import mrrc_pkg::*;

  localparam int unsigned IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  mrrc_stat_t       stat;
  logic             in_fire;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  assign in_fire = in_valid && in_ready;

  mrrc_dp #(
    .NUM_WORDS (NUM_WORDS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_fire         (in_fire),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .stat            (stat),
    .out_status      (out_status),
    .out_word_value  (out_word_value)
  );

  mrrc_ctrl #(
    .NUM_WORDS (NUM_WORDS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .stat           (stat),
    .in_ready       (in_ready),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr)
  );

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_word_index == 5'd0 && out_word_value == 16'h0000 && out_last_word))
    else $error("error transaction carries word payload");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> (out_last_word && out_ready))
    else $error("byte taken while results pending");

  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end_of_frame) |=> out_valid)
    else $error("no result after end of frame");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == 5'($past(out_word_index) + 5'd1)))
    else $error("word index did not advance");

endmodule
`default_nettype wire

@@ hw/rtl/mrrc_dp.sv @@
// Datapath: frame checks, CRC, word store and result payload registers.
`timescale 1ns / 1ps
`default_nettype none
module mrrc_dp #(
  parameter int unsigned NUM_WORDS = mrrc_pkg::NUM_WORDS_DEF,
  parameter int unsigned IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,
  input  wire logic                 in_fire,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_end_of_frame,
  input  wire logic                 rd_en,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output mrrc_pkg::mrrc_stat_t      stat,
  output logic [1:0]                out_status,
  output logic [15:0]               out_word_value
);
  import mrrc_pkg::*;

  localparam int unsigned FRAME_LEN = 2 * NUM_WORDS + 5;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN + 2);
  localparam logic [POS_W-1:0] P_FL      = POS_W'(FRAME_LEN);
  localparam logic [POS_W-1:0] P_LAST    = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] P_CRC_LO  = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] P_THREE   = POS_W'(3);
  localparam logic [7:0]       BYTE_CNT  = 8'(2 * NUM_WORDS);

  logic [7:0]       slave_addr_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hdr_r, hdr_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [7:0]       crclo_r, crclo_nxt;
  status_t          status_r, status_nxt;
  logic [15:0]      rd_data_r;
  logic [15:0]      mem [NUM_WORDS];

  logic [POS_W-1:0] off;
  logic             in_body;
  logic             we;
  logic [IDX_W-1:0] waddr;

  assign off     = pos_r - P_THREE;
  assign in_body = (pos_r >= P_THREE) && (pos_r < P_CRC_LO);
  assign we      = in_fire && in_body && off[0];
  assign waddr   = IDX_W'(off >> 1);

  always_comb begin
    if (pos_r != P_LAST) begin
      status_nxt = ST_LEN;
    end else if (!hdr_r) begin
      status_nxt = ST_HDR;
    end else if (crc_r != {in_data_byte, crclo_r}) begin
      status_nxt = ST_CRC;
    end else begin
      status_nxt = ST_OK;
    end
  end

  assign stat.frame_end = in_fire && in_end_of_frame;
  assign stat.frame_ok  = (status_nxt == ST_OK);

  always_comb begin
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    pend_nxt  = pend_r;
    crclo_nxt = crclo_r;
    if (in_fire) begin
      if (pos_r < P_FL) begin
        if (pos_r == POS_W'(0) && in_data_byte != slave_addr_r) hdr_nxt = 1'b0;
        if (pos_r == POS_W'(1) && in_data_byte != FUNC_READ) hdr_nxt = 1'b0;
        if (pos_r == POS_W'(2) && in_data_byte != BYTE_CNT) hdr_nxt = 1'b0;
        if (pos_r < P_CRC_LO) crc_nxt = crc_fold(crc_r, in_data_byte);
        if (in_body && !off[0]) pend_nxt = in_data_byte;
        if (pos_r == P_CRC_LO) crclo_nxt = in_data_byte;
      end
      if (pos_r <= P_FL) pos_nxt = pos_r + POS_W'(1);
      if (in_end_of_frame) begin
        crc_nxt   = CRC_INIT;
        pos_nxt   = '0;
        hdr_nxt   = 1'b1;
        pend_nxt  = '0;
        crclo_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_RESET;
      crc_r        <= CRC_INIT;
      pos_r        <= '0;
      hdr_r        <= 1'b1;
      pend_r       <= '0;
      crclo_r      <= '0;
      status_r     <= ST_OK;
    end else begin
      if (cfg_wr_en) slave_addr_r <= cfg_wr_data;
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      pend_r  <= pend_nxt;
      crclo_r <= crclo_nxt;
      if (stat.frame_end) status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {in_data_byte, pend_r};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_status     = status_r;
  assign out_word_value = (status_r == ST_OK) ? rd_data_r : 16'h0000;

endmodule
`default_nettype wire

@@ hw/rtl/mrrc_ctrl.sv @@
// Controller: receive/emit sequencing, word counter and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module mrrc_ctrl #(
  parameter int unsigned NUM_WORDS = mrrc_pkg::NUM_WORDS_DEF,
  parameter int unsigned IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mrrc_pkg::mrrc_stat_t stat,
  output logic                    in_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [4:0]              out_word_index,
  output logic                    out_last_word,
  output logic                    rd_en,
  output logic [IDX_W-1:0]        rd_addr
);
  import mrrc_pkg::*;

  localparam int unsigned XW = (IDX_W > 5) ? IDX_W : 5;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(NUM_WORDS - 1);

  typedef enum logic {
    S_RECV,
    S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic             out_fire;
  logic [XW-1:0]    idx_wide;

  assign out_valid     = (state_r == S_OUT);
  assign out_last_word = err_r || (cnt_r == CNT_LAST);
  assign out_fire      = out_valid && out_ready;
  assign in_ready      = (state_r == S_RECV) || (out_fire && out_last_word);
  assign idx_wide      = XW'(cnt_r);
  assign out_word_index = idx_wide[4:0];

  assign rd_en   = (stat.frame_end && stat.frame_ok) || (out_fire && !out_last_word);
  assign rd_addr = stat.frame_end ? '0 : cnt_r + IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    case (state_r)
      S_RECV: begin
        if (stat.frame_end) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
          err_nxt   = !stat.frame_ok;
        end
      end
      S_OUT: begin
        if (stat.frame_end) begin
          cnt_nxt = '0;
          err_nxt = !stat.frame_ok;
        end else if (out_fire && out_last_word) begin
          state_nxt = S_RECV;
        end else if (out_fire) begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
`default_nettype wire
